>>> design/tpa_pkg.sv
// Shared widths for the triangle perimeter and area core.
// No dependencies.
`default_nettype none
package tpa_pkg;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SQ_W    = 42;
  localparam int unsigned SIDE_W  = 21;
  localparam int unsigned PERIM_W = 23;
  localparam int unsigned FACT_W  = 23;
  localparam int unsigned HALF_W  = 2 * FACT_W;
  localparam int unsigned PROD_W  = 4 * FACT_W;
  localparam int unsigned ROOT_W  = PROD_W / 2;
  localparam int unsigned AREA_W  = 39;
endpackage
`default_nettype wire

>>> design/tpa_isqrt.sv
// Pipelined digit-by-digit floor square root, one root bit per stage, several lanes.
// No dependencies.
`default_nettype none
module tpa_isqrt #(
  parameter int unsigned LANES = 1,
  parameter int unsigned IN_W  = 42
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [IN_W-1:0]     rad_i  [LANES],
  output logic                vld_o,
  output logic [IN_W/2-1:0]   root_o [LANES]
);
  localparam int unsigned OUT_W  = IN_W / 2;
  localparam int unsigned REM_W  = OUT_W + 2;
  localparam int unsigned STAGES = OUT_W;

  logic [STAGES-1:0] vld_q;
  logic [IN_W-1:0]   rad_q  [STAGES][LANES];
  logic [REM_W-1:0]  rem_q  [STAGES][LANES];
  logic [OUT_W-1:0]  root_q [STAGES][LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], vld_i};
    end
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [IN_W-1:0]  cur_rad;
      logic [REM_W-1:0] cur_rem;
      logic [OUT_W-1:0] cur_root;
      logic [REM_W-1:0] rem_n;
      logic [REM_W-1:0] trial;
      if (s == 0) begin : g_first
        assign cur_rad  = rad_i[l];
        assign cur_rem  = '0;
        assign cur_root = '0;
      end else begin : g_next
        assign cur_rad  = rad_q[s-1][l];
        assign cur_rem  = rem_q[s-1][l];
        assign cur_root = root_q[s-1][l];
      end
      assign rem_n = {cur_rem[REM_W-3:0], cur_rad[IN_W-1 -: 2]};
      assign trial = {cur_root, 2'b01};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[s][l] <= {cur_rad[IN_W-3:0], 2'b00};
          if (rem_n >= trial) begin
            rem_q[s][l]  <= rem_n - trial;
            root_q[s][l] <= {cur_root[OUT_W-2:0], 1'b1};
          end else begin
            rem_q[s][l]  <= rem_n;
            root_q[s][l] <= {cur_root[OUT_W-2:0], 1'b0};
          end
        end
      end
      assign root_o[l] = root_q[STAGES-1][l];
    end
  end

  assign vld_o = vld_q[STAGES-1];
endmodule
`default_nettype wire

>>> design/tpa_mul46.sv
// Two-stage 46 x 46 unsigned multiplier built from four 23 x 23 partial products.
// Depends on tpa_pkg.
`default_nettype none
module tpa_mul46 (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [tpa_pkg::HALF_W-1:0] a_i,
  input  logic [tpa_pkg::HALF_W-1:0] b_i,
  output logic [tpa_pkg::PROD_W-1:0] prod_o
);
  import tpa_pkg::*;

  logic [HALF_W-1:0] ll_q, lh_q, hl_q, hh_q;
  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[FACT_W-1:0] * b_i[FACT_W-1:0];
      lh_q <= a_i[FACT_W-1:0] * b_i[HALF_W-1:FACT_W];
      hl_q <= a_i[HALF_W-1:FACT_W] * b_i[FACT_W-1:0];
      hh_q <= a_i[HALF_W-1:FACT_W] * b_i[HALF_W-1:FACT_W];
      prod_q <= {hh_q, ll_q}
              + {{(FACT_W-1){1'b0}}, ({1'b0, lh_q} + {1'b0, hl_q}), {FACT_W{1'b0}}};
    end
  end

  assign prod_o = prod_q;
endmodule
`default_nettype wire

>>> design/triangle_perimeter_area_core.sv
// Triangle perimeter and Heron area core, fixed point.
// Throughput one request per cycle while the result is not stalled.
// The depth is set by the side root (21 stages) and the area root (46 stages).
// All stages advance together; a stalled result holds the whole pipeline.
// Reset clears every valid bit; data registers are not reset.
// Depends on tpa_pkg, tpa_isqrt, tpa_mul46.
`default_nettype none
module triangle_perimeter_area_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [tpa_pkg::COORD_W-1:0] vertex_a_x_i,
  input  logic signed [tpa_pkg::COORD_W-1:0] vertex_a_y_i,
  input  logic signed [tpa_pkg::COORD_W-1:0] vertex_b_x_i,
  input  logic signed [tpa_pkg::COORD_W-1:0] vertex_b_y_i,
  input  logic signed [tpa_pkg::COORD_W-1:0] vertex_c_x_i,
  input  logic signed [tpa_pkg::COORD_W-1:0] vertex_c_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tpa_pkg::PERIM_W-1:0]        perimeter_o,
  output logic [tpa_pkg::AREA_W-1:0]         area_o
);
  import tpa_pkg::*;

  localparam int unsigned PLINE = 3 + ROOT_W;

  function automatic logic [COORD_W-1:0] absdiff(input logic signed [COORD_W-1:0] p,
                                                 input logic signed [COORD_W-1:0] q);
    logic signed [COORD_W:0] d;
    d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
    if (d[COORD_W]) begin
      d = -d;
    end
    return d[COORD_W-1:0];
  endfunction

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: coordinate differences
  logic               vld1_q;
  logic [COORD_W-1:0] dx_q [3];
  logic [COORD_W-1:0] dy_q [3];
  // stage 2: squared lengths scaled by 256
  logic               vld2_q;
  logic [SQ_W-1:0]    sq_q [3];
  // side roots
  logic               vld3;
  logic [SIDE_W-1:0]  side [3];
  // stage 4: perimeter and factors
  logic               vld4_q;
  logic [PERIM_W-1:0] p4_q;
  logic [FACT_W-1:0]  f_q [3];
  logic               pos4_q;
  logic signed [PERIM_W:0] f_n [3];
  // stage 5: pair products
  logic               vld5_q, vld6_q, vld7_q;
  logic [HALF_W-1:0]  x5_q, y5_q;
  logic [2:0]         pos_q;
  logic [PERIM_W-1:0] p_line_q [PLINE];
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  rad [1];
  logic               vld_r;
  logic [ROOT_W-1:0]  root [1];
  // output register
  logic               out_vld_q;
  logic [PERIM_W-1:0] perim_q;
  logic [AREA_W-1:0]  area_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q[0] <= absdiff(vertex_a_x_i, vertex_b_x_i);
      dy_q[0] <= absdiff(vertex_a_y_i, vertex_b_y_i);
      dx_q[1] <= absdiff(vertex_b_x_i, vertex_c_x_i);
      dy_q[1] <= absdiff(vertex_b_y_i, vertex_c_y_i);
      dx_q[2] <= absdiff(vertex_a_x_i, vertex_c_x_i);
      dy_q[2] <= absdiff(vertex_a_y_i, vertex_c_y_i);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq
    logic [2*COORD_W-1:0] dx2;
    logic [2*COORD_W-1:0] dy2;
    logic [2*COORD_W:0]   ssum;
    assign dx2  = dx_q[i] * dx_q[i];
    assign dy2  = dy_q[i] * dy_q[i];
    assign ssum = {1'b0, dx2} + {1'b0, dy2};
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[i] <= {1'b0, ssum, 8'h00};
      end
    end
  end

  tpa_isqrt #(.LANES(3), .IN_W(SQ_W)) u_side_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld2_q),
    .rad_i  (sq_q),
    .vld_o  (vld3),
    .root_o (side)
  );

  logic [PERIM_W-1:0] p_n;
  assign p_n = {2'b00, side[0]} + {2'b00, side[1]} + {2'b00, side[2]};
  for (genvar i = 0; i < 3; i++) begin : g_fact
    assign f_n[i] = $signed({1'b0, p_n}) - $signed({2'b00, side[i], 1'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_q   <= p_n;
      f_q[0] <= f_n[0][FACT_W-1:0];
      f_q[1] <= f_n[1][FACT_W-1:0];
      f_q[2] <= f_n[2][FACT_W-1:0];
      pos4_q <= (f_n[0] > 0) && (f_n[1] > 0) && (f_n[2] > 0);
      x5_q   <= p4_q * f_q[0];
      y5_q   <= f_q[1] * f_q[2];
      pos_q  <= {pos_q[1:0], pos4_q};
      p_line_q[0] <= p4_q;
      for (int k = 1; k < PLINE; k++) begin
        p_line_q[k] <= p_line_q[k-1];
      end
    end
  end

  tpa_mul46 u_mul (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (x5_q),
    .b_i    (y5_q),
    .prod_o (prod)
  );

  assign rad[0] = pos_q[2] ? prod : '0;

  tpa_isqrt #(.LANES(1), .IN_W(PROD_W)) u_area_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld7_q),
    .rad_i  (rad),
    .vld_o  (vld_r),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      perim_q <= p_line_q[PLINE-1];
      if (root[0][ROOT_W-1:AREA_W+2] != '0) begin
        area_q <= '1;
      end else begin
        area_q <= root[0][AREA_W+1:2];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld4_q    <= 1'b0;
      vld5_q    <= 1'b0;
      vld6_q    <= 1'b0;
      vld7_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld1_q    <= in_valid_i;
      vld2_q    <= vld1_q;
      vld4_q    <= vld3;
      vld5_q    <= vld4_q;
      vld6_q    <= vld5_q;
      vld7_q    <= vld6_q;
      out_vld_q <= vld_r;
    end
  end

  assign out_valid_o = out_vld_q;
  assign perimeter_o = perim_q;
  assign area_o      = area_q;

  a_area_needs_perim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (area_o != '0) |-> (perimeter_o != '0))
    else $error("nonzero area with zero perimeter");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while result stalled");

  a_pos_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld4_q && pos4_q |-> (p4_q != '0))
    else $error("positive factors with zero perimeter");
endmodule
`default_nettype wire

>>> test/testbench.sv
// Testbench for triangle_perimeter_area_core: random and corner-case triangles.
// Predicts perimeter and Heron area in the testbench and checks each result in order.
// Depends on tpa_pkg and triangle_perimeter_area_core.
`timescale 1ns / 100ps
module testbench;
  import tpa_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
  } triangle_t;

  typedef struct packed {
    logic [PERIM_W-1:0] perim;
    logic [AREA_W-1:0]  area;
  } measure_t;

  localparam int unsigned LATENCY = 74;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  triangle_t cur_tri;
  logic [PERIM_W-1:0] perim_out;
  logic [AREA_W-1:0]  area_out;

  triangle_t pending_tris[$];
  measure_t  expected_measures[$];
  int unsigned n_sent, n_checked, n_bad, n_degenerate;
  int unsigned send_wait, recv_wait, hold_cycles;
  longint unsigned cycles;
  bit stim_done;
  bit in_taken, out_taken;

  triangle_perimeter_area_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .vertex_a_x_i(cur_tri.ax), .vertex_a_y_i(cur_tri.ay),
    .vertex_b_x_i(cur_tri.bx), .vertex_b_y_i(cur_tri.by),
    .vertex_c_x_i(cur_tri.cx), .vertex_c_y_i(cur_tri.cy),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .perimeter_o(perim_out), .area_o(area_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] floor_root(logic [127:0] v, int unsigned top_bit);
    logic [63:0] r, t;
    r = '0;
    for (int b = top_bit; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (128'(t) * 128'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [SIDE_W-1:0] side_length(longint x1, longint y1,
                                                      longint x2, longint y2);
    longint dx, dy;
    dx = x1 - x2;
    dy = y1 - y2;
    return SIDE_W'(floor_root(128'((dx * dx + dy * dy) * 256), 20));
  endfunction

  function automatic measure_t heron_measure(triangle_t t);
    measure_t m;
    longint sab, sbc, sac, p, f1, f2, f3;
    logic [127:0] rad;
    logic [63:0] a;
    sab = side_length(t.ax, t.ay, t.bx, t.by);
    sbc = side_length(t.bx, t.by, t.cx, t.cy);
    sac = side_length(t.ax, t.ay, t.cx, t.cy);
    p = sab + sbc + sac;
    f1 = p - 2 * sab;
    f2 = p - 2 * sbc;
    f3 = p - 2 * sac;
    a = '0;
    if (f1 > 0 && f2 > 0 && f3 > 0) begin
      rad = (128'(p) * 128'(f1)) * (128'(f2) * 128'(f3));
      a = floor_root(rad, 46) >> 2;
      if (a > 64'((64'd1 << AREA_W) - 1)) a = (64'd1 << AREA_W) - 1;
    end
    m.perim = p[PERIM_W-1:0];
    m.area = a[AREA_W-1:0];
    return m;
  endfunction

  function automatic logic [15:0] rand_coord(int unsigned mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 64)) - 16'd32;
      2: return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 8))
                                     : 16'h8000 + 16'($urandom_range(0, 8));
      default: return 16'($urandom_range(0, 4000)) - 16'd2000;
    endcase
  endfunction

  task automatic add_tri(logic [15:0] ax, ay, bx, by, cx, cy);
    triangle_t t;
    t = {ax, ay, bx, by, cx, cy};
    pending_tris.push_back(t);
  endtask

  initial begin
    triangle_t t;
    int unsigned mode;
    add_tri(0, 0, 0, 0, 0, 0);
    add_tri(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    add_tri(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    add_tri(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
    add_tri(0, 0, 16, 0, 0, 16);
    add_tri(0, 0, 48, 0, 0, 64);
    add_tri(0, 0, 1, 0, 0, 1);
    add_tri(0, 0, 1, 1, 2, 2);
    add_tri(0, 0, 100, 100, 16'hff9c, 16'hff9c);
    add_tri(5, 5, 5, 5, 100, 7);
    add_tri(0, 0, 1000, 1, 2000, 3);
    add_tri(16'hffff, 16'hffff, 16'hffff, 0, 0, 16'hffff);
    add_tri(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h0f0f, 16'hf0f0);
    add_tri(16'h7fff, 0, 16'h8000, 0, 0, 1);
    add_tri(0, 16'h7fff, 0, 16'h8000, 1, 0);
    add_tri(3, 7, 3, 7, 3, 7);
    repeat (1700) begin
      mode = $urandom_range(0, 3);
      if ($urandom_range(0, 5) == 0) begin
        t.ax = rand_coord(mode);
        t.ay = rand_coord(mode);
        t.bx = 16'(t.ax + 2 * $signed(16'($urandom_range(0, 20)) - 16'sd10));
        t.by = 16'(t.ay + 2 * $signed(16'($urandom_range(0, 20)) - 16'sd10));
        t.cx = 16'(2 * t.bx - t.ax);
        t.cy = 16'(2 * t.by - t.ay);
      end else begin
        t = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode)};
      end
      pending_tris.push_back(t);
    end
    stim_done = 1'b1;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // sender: drive at falling edge, hold until accepted
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cur_tri <= '0;
      send_wait <= 0;
    end else if (in_valid && !in_taken) begin
    end else if (send_wait != 0) begin
      in_valid <= 1'b0;
      send_wait <= send_wait - 1;
    end else if (pending_tris.size() != 0) begin
      cur_tri <= pending_tris.pop_front();
      in_valid <= 1'b1;
      send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random stalls plus one long hold once traffic is flowing
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
      hold_cycles <= 0;
    end else if (n_sent == 200 && hold_cycles == 0) begin
      hold_cycles <= 400;
      out_ready <= 1'b0;
    end else if (hold_cycles > 1) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_taken)
        recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_measures.push_back(heron_measure(cur_tri));
      n_sent <= n_sent + 1;
    end
  end

  always @(posedge clk) begin
    measure_t exp_m;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_measures.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result perim=%0d area=%0d", perim_out, area_out);
      end else begin
        exp_m = expected_measures.pop_front();
        if (exp_m.area == 0) n_degenerate++;
        if (perim_out !== exp_m.perim || area_out !== exp_m.area) begin
          n_bad++;
          if (n_bad <= 10)
            $display("result %0d: perim exp %0d got %0d, area exp %0d got %0d", n_checked,
                     exp_m.perim, perim_out, exp_m.area, area_out);
        end
      end
      n_checked++;
    end
  end

  initial begin
    cycles = 0;
    @(posedge rst_n);
    while (!(stim_done && pending_tris.size() == 0 && !in_valid &&
             expected_measures.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("triangle_perimeter_area_core: mismatch");
      $finish;
    end else begin
      repeat (2 * LATENCY) @(posedge clk);
      $display("checked %0d triangles, %0d with zero area; long output stall applied",
               n_checked, n_degenerate);
      if (n_bad == 0 && expected_measures.size() == 0) begin
        $display("triangle_perimeter_area_core: match");
      end else begin
        $display("triangle_perimeter_area_core: mismatch");
      end
      $finish;
    end
  end
endmodule

>>> sim.f
design/tpa_pkg.sv
design/tpa_isqrt.sv
design/tpa_mul46.sv
design/triangle_perimeter_area_core.sv
test/testbench.sv
